### rtl/mmau_pkg.sv
// ----------------------------------------------------------------------------
// mmau_pkg
// Shared types and codes for the multichannel moving average unit.
// ----------------------------------------------------------------------------
package mmau_pkg;

    localparam int unsigned DATA_W = 16;

    typedef logic signed [DATA_W-1:0] t_sample;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_FILL   = 1'b1
    } t_kind;

endpackage

### rtl/mmau_in_if.sv
// ----------------------------------------------------------------------------
// mmau_in_if
// Input channel: sample or fill beats with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mmau_in_if;
    import mmau_pkg::*;

    logic    valid;
    logic    ready;
    t_kind   kind;
    logic    channel;
    t_sample sample_value;

    modport source (output valid, output kind, output channel, output sample_value,
                    input ready);
    modport sink   (input valid, input kind, input channel, input sample_value,
                    output ready);
endinterface

### rtl/mmau_out_if.sv
// ----------------------------------------------------------------------------
// mmau_out_if
// Output channel: average beats with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mmau_out_if;
    import mmau_pkg::*;

    logic    valid;
    logic    ready;
    t_sample average;
    logic    channel_out;

    modport source (output valid, output average, output channel_out, input ready);
    modport sink   (input valid, input average, input channel_out, output ready);
endinterface

### rtl/mmau_ring_mem.sv
// ----------------------------------------------------------------------------
// mmau_ring_mem
// Sample ring store, one port, read-first, registered read data.
// ----------------------------------------------------------------------------
module mmau_ring_mem #(
    parameter int unsigned AW = 5
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_we,
    input  logic [AW-1:0]     i_addr,
    input  mmau_pkg::t_sample i_wdata,
    output mmau_pkg::t_sample o_rdata
);
    import mmau_pkg::*;

    localparam int unsigned DEPTH = 2 ** AW;

    t_sample r_mem [DEPTH];
    t_sample r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata <= r_mem[i_addr];
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/mmau_avg_div.sv
// ----------------------------------------------------------------------------
// mmau_avg_div
// Sum / WINDOW truncated toward zero: magnitude times reciprocal, then
// shift and sign restore into the output register.
// ----------------------------------------------------------------------------
module mmau_avg_div #(
    parameter int unsigned WINDOW = 16,
    parameter int unsigned SW     = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [SW-1:0] i_sum,
    input  logic                 i_channel,
    mmau_out_if.source           o_out
);
    import mmau_pkg::*;

    localparam int unsigned L   = (WINDOW > 1) ? $clog2(WINDOW) : 0;
    localparam int unsigned K   = SW + L;
    localparam int unsigned MW  = SW + 1;
    localparam int unsigned PRW = SW + MW;
    localparam longint unsigned RECIP_L = ((64'd1 << K) + 64'(WINDOW) - 64'd1)
                                          / 64'(WINDOW);
    localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

    logic            r_a_valid;
    logic [PRW-1:0]  r_a_prod;
    logic            r_a_neg;
    logic            r_a_ch;
    logic            r_o_valid;
    t_sample         r_o_avg;
    logic            r_o_ch;

    logic            en_out;
    logic            en_a;
    logic [SW-1:0]   mag;
    logic [PRW-1:0]  n_prod;
    logic [DATA_W-1:0] quot;
    t_sample         n_avg;

    assign en_out  = !r_o_valid || o_out.ready;
    assign en_a    = !r_a_valid || en_out;
    assign o_ready = en_a;

    always_comb begin
        mag    = i_sum[SW-1] ? SW'(-i_sum) : SW'(i_sum);
        n_prod = PRW'(mag) * PRW'(RECIP);
        quot   = r_a_prod[K +: DATA_W];
        n_avg  = r_a_neg ? t_sample'(-quot) : t_sample'(quot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_valid <= i_valid;
            end
            if (en_out) begin
                r_o_valid <= r_a_valid;
            end
        end
        if (en_a && i_valid) begin
            r_a_prod <= n_prod;
            r_a_neg  <= i_sum[SW-1];
            r_a_ch   <= i_channel;
        end
        if (en_out && r_a_valid) begin
            r_o_avg <= n_avg;
            r_o_ch  <= r_a_ch;
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.average     = r_o_avg;
    assign o_out.channel_out = r_o_ch;

endmodule

### rtl/multichannel_moving_average_unit.sv
// ----------------------------------------------------------------------------
// multichannel_moving_average_unit
// Per-channel boxcar moving average over the last WINDOW samples.
//
//   channel  dir  handshake    payload
//   i_in     in   valid/ready  kind, channel, sample_value
//   o_out    out  valid/ready  average, channel_out
//
// One beat per cycle sustained while o_out is ready, any channel mix.
// A sample passes these registered steps on its way to o_out: ring read
// at acceptance, running-sum update, reciprocal multiply, shift and sign
// into the output register.
// Fill beats are absorbed at the running-sum stage and give no output.
// Reset is a fill with zero on every channel; no memory clear pass.
// Each stage moves when the one after it is empty or moving, so input can
// still be taken while a result waits on o_out if an earlier stage is empty.
// ----------------------------------------------------------------------------
module multichannel_moving_average_unit #(
    parameter int unsigned WINDOW   = 16,
    parameter int unsigned CHANNELS = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mmau_in_if.sink   i_in,
    mmau_out_if.source o_out
);
    import mmau_pkg::*;

    localparam int unsigned PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned AW = CW + PW;
    localparam int unsigned SW = DATA_W + ((WINDOW > 1) ? $clog2(WINDOW) : 0);
    localparam logic [PW-1:0]        POS_LAST = PW'(WINDOW - 1);
    localparam logic signed [SW-1:0] WIN_S    = SW'(WINDOW);

    logic [PW-1:0]        r_pos     [CHANNELS];
    logic                 r_wrapped [CHANNELS];
    t_sample              r_fill    [CHANNELS];
    logic signed [SW-1:0] r_sum     [CHANNELS];

    logic                 r_s1_valid;
    t_kind                r_s1_kind;
    logic                 r_s1_ch;
    t_sample              r_s1_val;
    logic                 r_s1_use_fill;
    t_sample              r_s1_fill;

    logic                 r_s2_valid;
    logic signed [SW-1:0] r_s2_sum;
    logic                 r_s2_ch;

    logic                 accept;
    logic                 take;
    logic [CW-1:0]        in_idx;
    logic [CW-1:0]        s1_idx;
    logic [PW-1:0]        cur_pos;
    logic                 en1;
    logic                 en2;
    logic                 div_ready;
    t_sample              mem_rdata;
    t_sample              old_val;
    logic signed [SW-1:0] n_sum;

    assign in_idx  = CW'(i_in.channel);
    assign s1_idx  = CW'(r_s1_ch);
    assign cur_pos = r_pos[in_idx];
    assign en2     = !r_s2_valid || div_ready;
    assign en1     = !r_s1_valid || en2;
    assign i_in.ready = en1;
    assign accept  = i_in.valid && en1;
    assign take    = accept && (32'(i_in.channel) < 32'(CHANNELS));

    mmau_ring_mem #(.AW(AW)) u_ring (
        .i_clk   (i_clk),
        .i_en    (take),
        .i_we    (i_in.kind == KIND_SAMPLE),
        .i_addr  ({in_idx, cur_pos}),
        .i_wdata (i_in.sample_value),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        old_val = r_s1_use_fill ? r_s1_fill : mem_rdata;
        if (r_s1_kind == KIND_FILL) begin
            n_sum = SW'(r_s1_val) * WIN_S;
        end else begin
            n_sum = r_sum[s1_idx] + SW'(r_s1_val) - SW'(old_val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_pos[c]     <= '0;
                r_wrapped[c] <= 1'b0;
                r_fill[c]    <= '0;
                r_sum[c]     <= '0;
            end
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (take) begin
                if (i_in.kind == KIND_FILL) begin
                    r_pos[in_idx]     <= '0;
                    r_wrapped[in_idx] <= 1'b0;
                    r_fill[in_idx]    <= i_in.sample_value;
                end else if (cur_pos == POS_LAST) begin
                    r_pos[in_idx]     <= '0;
                    r_wrapped[in_idx] <= 1'b1;
                end else begin
                    r_pos[in_idx]     <= cur_pos + 1'b1;
                end
            end
            if (en1) begin
                r_s1_valid <= take;
            end
            if (en2) begin
                r_s2_valid <= r_s1_valid && (r_s1_kind == KIND_SAMPLE);
            end
            if (r_s1_valid && en2) begin
                r_sum[s1_idx] <= n_sum;
            end
        end
        if (take) begin
            r_s1_kind     <= i_in.kind;
            r_s1_ch       <= i_in.channel;
            r_s1_val      <= i_in.sample_value;
            r_s1_use_fill <= !r_wrapped[in_idx];
            r_s1_fill     <= r_fill[in_idx];
        end
        if (r_s1_valid && en2) begin
            r_s2_sum <= n_sum;
            r_s2_ch  <= r_s1_ch;
        end
    end

    mmau_avg_div #(.WINDOW(WINDOW), .SW(SW)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_s2_valid),
        .o_ready   (div_ready),
        .i_sum     (r_s2_sum),
        .i_channel (r_s2_ch),
        .o_out     (o_out)
    );

endmodule
